### design/proportional_glyph_layout_defines.svh
// Assertion macros for the checker file of the glyph layout block.
// Each macro expects clk in the scope where it is used; all but PGL_ASSERT_ALWAYS also rst.
`ifndef PROPORTIONAL_GLYPH_LAYOUT_DEFINES_SVH
`define PROPORTIONAL_GLYPH_LAYOUT_DEFINES_SVH

// same-cycle implication, muted during reset
`define PGL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, muted during reset
`define PGL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define PGL_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### design/pgl_pkg.sv
// Shared types and constants of the proportional glyph layout block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pgl_pkg;

  localparam int GLYPH_COUNT      = 95;
  localparam int GLYPH_WIDTH_BITS = 8;

  localparam int IDX_W   = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int SRC_X_W = 15;
  localparam int PROD_W  = GLYPH_WIDTH_BITS + 8;
  localparam int CNT_W   = $clog2(PROD_W);

  localparam logic [7:0] FIRST_CODE  = 8'd32;
  localparam logic [7:0] END_CODE    = 8'd127;
  localparam logic [8:0] GLYPH_LIMIT = 9'(GLYPH_COUNT);

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_CHAR  = 2'd2;

  localparam logic [1:0] CFG_STRIP_HEIGHT = 2'd0;
  localparam logic [1:0] CFG_FONT_SIZE    = 2'd1;
  localparam logic [1:0] CFG_DRAW_COLOR   = 2'd2;

  localparam logic [7:0]  RST_STRIP_HEIGHT = 8'd8;
  localparam logic [7:0]  RST_FONT_SIZE    = 8'd8;
  localparam logic [31:0] RST_DRAW_COLOR   = 32'h00FF_FFFF;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         char_code;
    logic [7:0]         glyph_width;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
  } cmd_t;

  typedef struct packed {
    logic [14:0]        src_x;
    logic [7:0]         src_width;
    logic [7:0]         src_height;
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic [15:0]        dest_width;
    logic [7:0]         dest_height;
    logic [31:0]        color;
  } rect_t;

  typedef struct packed {
    logic                        start;
    logic [GLYPH_WIDTH_BITS-1:0] w;
    logic [7:0]                  font_size;
    logic [7:0]                  strip_height;
  } scl_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } scl_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_SCALE,
    ST_DONE
  } lay_state_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_DIV
  } scl_state_t;

endpackage

### design/pgl_width_ram.sv
// Glyph width table: one write port, one registered read port.
// Depends on pgl_pkg for depth and entry width.
`timescale 1ns / 1ps

module pgl_width_ram (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [pgl_pkg::IDX_W-1:0]            waddr,
  input  logic [pgl_pkg::GLYPH_WIDTH_BITS-1:0] wdata,
  input  logic                                 re,
  input  logic [pgl_pkg::IDX_W-1:0]            raddr,
  output logic [pgl_pkg::GLYPH_WIDTH_BITS-1:0] rdata
);

  logic [pgl_pkg::GLYPH_WIDTH_BITS-1:0] mem [pgl_pkg::GLYPH_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/pgl_scale.sv
// Bit-serial width scaler: shift-add multiply of width by font size, then
// restoring division by strip height, one bit per cycle. Depends on pgl_pkg.
`timescale 1ns / 1ps

module pgl_scale (
  input  logic              clk,
  input  logic              rst,
  input  pgl_pkg::scl_req_t req,
  output pgl_pkg::scl_sts_t sts
);

  pgl_pkg::scl_state_t state, state_next;

  logic [pgl_pkg::CNT_W-1:0]            cnt;
  logic [pgl_pkg::GLYPH_WIDTH_BITS-1:0] mplier;
  logic [pgl_pkg::PROD_W-1:0]           mcand;
  logic [pgl_pkg::PROD_W-1:0]           acc;
  logic [7:0]                           divisor;
  logic [7:0]                           rem;
  logic                                 done;

  logic [8:0] trial;
  logic [8:0] diff;
  logic       fits;

  // next partial remainder: bring down the top dividend bit
  assign trial = {rem, acc[pgl_pkg::PROD_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pgl_pkg::SC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pgl_pkg::SC_IDLE: begin
        if (req.start) begin
          state_next = pgl_pkg::SC_MUL;
        end
      end
      pgl_pkg::SC_MUL: begin
        if (cnt == '0) begin
          state_next = pgl_pkg::SC_DIV;
        end
      end
      pgl_pkg::SC_DIV: begin
        if (cnt == '0) begin
          state_next = pgl_pkg::SC_IDLE;
        end
      end
      default: state_next = pgl_pkg::SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == pgl_pkg::SC_DIV) && (cnt == '0);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      pgl_pkg::SC_IDLE: begin
        if (req.start) begin
          mplier  <= req.w;
          mcand   <= pgl_pkg::PROD_W'(req.font_size);
          acc     <= '0;
          rem     <= '0;
          divisor <= req.strip_height;
          cnt     <= pgl_pkg::CNT_W'(pgl_pkg::GLYPH_WIDTH_BITS - 1);
        end
      end
      pgl_pkg::SC_MUL: begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mplier <= mplier >> 1;
        mcand  <= mcand << 1;
        if (cnt == '0) begin
          cnt <= pgl_pkg::CNT_W'(pgl_pkg::PROD_W - 1);
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      pgl_pkg::SC_DIV: begin
        // quotient bits shift in where the dividend shifts out
        acc <= {acc[pgl_pkg::PROD_W-2:0], fits};
        rem <= fits ? diff[7:0] : trial[7:0];
        cnt <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

  assign sts.done = done;
  assign sts.quot = (divisor == '0) ? 16'd0 : 16'(acc);

endmodule

### design/proportional_glyph_layout.sv
// Proportional glyph layout. Load and start items are handled in idle, as is
// a character item that draws nothing. A drawn character holds off the next
// item until it is done, and longer while the previous rectangle is still
// held in the output register: the source column is summed by walking the
// width table one entry per cycle through its single read port, then the
// screen width is formed by an 8-step shift-add multiply and a 16-step
// restoring division in the scaler. One item is in work at a time; a finished
// rectangle waits in the output register while the next item is taken.
// Configuration must be written through cfg_we/cfg_index/cfg_wdata only while
// the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module proportional_glyph_layout (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  pgl_pkg::cmd_t  cmd,
  output logic           rect_valid,
  input  logic           rect_ready,
  output pgl_pkg::rect_t rect,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_wdata
);

  pgl_pkg::lay_state_t state, state_next;

  logic [7:0]  strip_height;
  logic [7:0]  font_size;
  logic [31:0] draw_color;

  logic [15:0] pen_x;
  logic [15:0] pen_y;

  logic [pgl_pkg::IDX_W-1:0]            gidx;
  logic [pgl_pkg::IDX_W-1:0]            cnt;
  logic [pgl_pkg::SRC_X_W-1:0]          sum;
  logic [pgl_pkg::GLYPH_WIDTH_BITS-1:0] w;
  logic                                 issued_all;
  logic                                 pend;
  logic                                 pend_last;

  logic                                 cmd_acc;
  logic [7:0]                           code_off;
  logic                                 glyph_ok;
  logic                                 load_we;
  logic                                 rd_en;
  logic [pgl_pkg::GLYPH_WIDTH_BITS-1:0] rd_data;
  logic                                 rect_load;

  pgl_pkg::scl_req_t scl_req;
  pgl_pkg::scl_sts_t scl_sts;

  assign cmd_acc  = cmd_valid && cmd_ready;
  assign code_off = cmd.char_code - pgl_pkg::FIRST_CODE;
  assign glyph_ok = (cmd.char_code >= pgl_pkg::FIRST_CODE) &&
                    (cmd.char_code < pgl_pkg::END_CODE) &&
                    ({1'b0, code_off} < pgl_pkg::GLYPH_LIMIT);
  assign load_we  = cmd_acc && (cmd.opcode == pgl_pkg::OP_LOAD) &&
                    ({1'b0, cmd.char_code} < pgl_pkg::GLYPH_LIMIT);
  assign rd_en    = (state == pgl_pkg::ST_SUM) && !issued_all;

  pgl_width_ram u_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (cmd.char_code[pgl_pkg::IDX_W-1:0]),
    .wdata (pgl_pkg::GLYPH_WIDTH_BITS'(cmd.glyph_width)),
    .re    (rd_en),
    .raddr (cnt),
    .rdata (rd_data)
  );

  // the read of the glyph itself comes back last and starts the scaler
  assign scl_req.start        = (state == pgl_pkg::ST_SUM) && pend && pend_last;
  assign scl_req.w            = rd_data;
  assign scl_req.font_size    = font_size;
  assign scl_req.strip_height = strip_height;

  pgl_scale u_scale (
    .clk (clk),
    .rst (rst),
    .req (scl_req),
    .sts (scl_sts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pgl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    rect_load  = 1'b0;
    case (state)
      pgl_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid && (cmd.opcode == pgl_pkg::OP_CHAR) && glyph_ok) begin
          state_next = pgl_pkg::ST_SUM;
        end
      end
      pgl_pkg::ST_SUM: begin
        if (pend && pend_last) begin
          state_next = pgl_pkg::ST_SCALE;
        end
      end
      pgl_pkg::ST_SCALE: begin
        if (scl_sts.done) begin
          state_next = pgl_pkg::ST_DONE;
        end
      end
      pgl_pkg::ST_DONE: begin
        if (!rect_valid || rect_ready) begin
          rect_load  = 1'b1;
          state_next = pgl_pkg::ST_IDLE;
        end
      end
      default: state_next = pgl_pkg::ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strip_height <= pgl_pkg::RST_STRIP_HEIGHT;
      font_size    <= pgl_pkg::RST_FONT_SIZE;
      draw_color   <= pgl_pkg::RST_DRAW_COLOR;
    end else if (cfg_we) begin
      case (cfg_index)
        pgl_pkg::CFG_STRIP_HEIGHT: strip_height <= cfg_wdata[7:0];
        pgl_pkg::CFG_FONT_SIZE:    font_size    <= cfg_wdata[7:0];
        pgl_pkg::CFG_DRAW_COLOR:   draw_color   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pen position
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= '0;
      pen_y <= '0;
    end else if (cmd_acc && (cmd.opcode == pgl_pkg::OP_START)) begin
      pen_x <= cmd.start_x;
      pen_y <= cmd.start_y;
    end else if (rect_load) begin
      pen_x <= pen_x + scl_sts.quot;
    end
  end

  // prefix-sum walk: one table read issued per cycle, data back in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      issued_all <= 1'b1;
      pend       <= 1'b0;
      pend_last  <= 1'b0;
    end else if (state == pgl_pkg::ST_IDLE) begin
      if (cmd_acc) begin
        gidx       <= code_off[pgl_pkg::IDX_W-1:0];
        cnt        <= '0;
        sum        <= '0;
        issued_all <= 1'b0;
        pend       <= 1'b0;
      end
    end else if (state == pgl_pkg::ST_SUM) begin
      if (!issued_all) begin
        pend      <= 1'b1;
        pend_last <= (cnt == gidx);
        if (cnt == gidx) begin
          issued_all <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end else begin
        pend <= 1'b0;
      end
      if (pend) begin
        if (pend_last) begin
          w <= rd_data;
        end else begin
          sum <= sum + pgl_pkg::SRC_X_W'(rd_data);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_valid <= 1'b0;
    end else if (rect_load) begin
      rect_valid <= 1'b1;
    end else if (rect_ready) begin
      rect_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rect_load) begin
      rect.src_x       <= sum;
      rect.src_width   <= 8'(w);
      rect.src_height  <= strip_height;
      rect.dest_x      <= pen_x;
      rect.dest_y      <= pen_y;
      rect.dest_width  <= scl_sts.quot;
      rect.dest_height <= font_size;
      rect.color       <= draw_color;
    end
  end

endmodule

### design/pgl_checker.sv
// Port-level checks on the glyph layout block, bound to its top level.
// Depends on pgl_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "proportional_glyph_layout_defines.svh"

module pgl_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_ready,
  input pgl_pkg::cmd_t  cmd,
  input logic           rect_valid,
  input logic           rect_ready,
  input pgl_pkg::rect_t rect
);

  logic cmd_stall;
  logic rect_stall;
  logic empty_glyph;
  logic shrinking;

  assign cmd_stall   = cmd_valid && !cmd_ready;
  assign rect_stall  = rect_valid && !rect_ready;
  assign empty_glyph = rect_valid && (rect.src_width == 8'd0 || rect.src_height == 8'd0);
  assign shrinking   = rect_valid && (rect.dest_height <= rect.src_height);

  `PGL_ASSERT_ALWAYS(a_no_rect_after_reset, rst, !rect_valid, "item shown out of reset")
  `PGL_ASSERT_NEXT(a_cmd_held, cmd_stall, cmd_valid && $stable(cmd), "waiting item changed")
  `PGL_ASSERT_NEXT(a_rect_held, rect_stall, rect_valid && $stable(rect), "stalled item changed")
  `PGL_ASSERT_NOW(a_zero_width, empty_glyph, rect.dest_width == 16'd0, "empty glyph scaled")
  `PGL_ASSERT_NOW(a_no_growth, shrinking, rect.dest_width <= 16'(rect.src_width), "width grew")

endmodule

bind proportional_glyph_layout pgl_checker u_pgl_checker (.*);
